### hdl/gmse_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gmse_pkg
// Shared types and constants for the guest memory string engine: action codes,
// controller states, and the command and status groups between the
// controller and the datapath.
// ----------------------------------------------------------------------------
package gmse_pkg;

  localparam int MEM_BYTES_DEFAULT = 65536;
  localparam logic [7:0] BYTE_MASK = 8'hFF;

  typedef enum logic [3:0] {
    ACT_WRITE   = 4'd0,
    ACT_READ    = 4'd1,
    ACT_COPY    = 4'd2,
    ACT_SET     = 4'd3,
    ACT_MEMCMP  = 4'd4,
    ACT_STRNLEN = 4'd5,
    ACT_STRLEN  = 4'd6,
    ACT_STRCMP  = 4'd7,
    ACT_STRNCMP = 4'd8,
    ACT_STRCPY  = 4'd9,
    ACT_STRNCPY = 4'd10,
    ACT_STRCHR  = 4'd11
  } act_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_CHECK,
    ST_TEST,
    ST_RD_A,
    ST_RD_B,
    ST_EVAL,
    ST_DONE
  } state_t;

  // loop bound selection
  typedef enum logic [2:0] {
    LIM_OP2,
    LIM_STRN,
    LIM_AVAIL0,
    LIM_AVAIL1,
    LIM_CMP,
    LIM_CPY
  } lim_sel_t;

  // result selection
  typedef enum logic [2:0] {
    RES_ZERO,
    RES_OP0,
    RES_CNT,
    RES_BYTE,
    RES_DIFF,
    RES_ADDR
  } res_sel_t;

  // write data selection
  typedef enum logic [1:0] {
    WD_OP1,
    WD_RDATA,
    WD_ZERO,
    WD_CLEAR
  } wd_sel_t;

  typedef struct packed {
    logic     load;
    logic     clr_cnt;
    logic     inc_cnt;
    logic     lim_load;
    lim_sel_t lim_sel;
    logic     latch_a;
    logic     raddr_b;
    logic     copy_rev;
    logic     we;
    wd_sel_t  wd_sel;
    logic     res_load;
    res_sel_t res_sel;
    logic     set_ended;
  } dp_cmd_t;

  typedef struct packed {
    act_t act;
    logic in0;
    logic in1;
    logic z2;
    logic fit0;
    logic fit1;
    logic fit_cpy;
    logic done_idx;
    logic src_end;
    logic clr_last;
    logic byte_zero;
    logic byte_ne;
    logic needle_hit;
    logic ended;
  } dp_status_t;

endpackage

### hdl/gmse_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gmse_ram
// Generic simple dual port RAM: one write port, one read port with
// registered read data.
// ----------------------------------------------------------------------------
module gmse_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### hdl/gmse_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gmse_dp
// Datapath: operand registers, byte index counter, loop bound, range checks,
// byte memory and result register.
// ----------------------------------------------------------------------------
module gmse_dp #(
  parameter int MEM_BYTES = gmse_pkg::MEM_BYTES_DEFAULT
) (
  input  logic                clk,
  input  logic                rst,
  input  gmse_pkg::dp_cmd_t   cmd,
  output gmse_pkg::dp_status_t status,
  input  logic [3:0]          action,
  input  logic [63:0]         first_operand,
  input  logic [63:0]         second_operand,
  input  logic [63:0]         third_operand,
  output logic [63:0]         result_value
);
  import gmse_pkg::*;

  localparam int AW = $clog2(MEM_BYTES);
  localparam int CW = $clog2(MEM_BYTES + 1);
  localparam logic [63:0] MEM_W = 64'(MEM_BYTES);
  localparam logic [CW-1:0] CNT_LAST = CW'(MEM_BYTES - 1);

  act_t        act;
  logic [63:0] op0;
  logic [63:0] op1;
  logic [63:0] op2;
  logic [CW-1:0] cnt;
  logic [CW-1:0] lim;
  logic [CW-1:0] lim_next;
  logic [7:0]  byte_a;
  logic        ended;
  logic        backward;
  logic [63:0] res;
  logic [63:0] res_next;

  logic [CW-1:0] avail0;
  logic [CW-1:0] avail1;
  logic [CW-1:0] min_avail;
  logic [CW-1:0] j;
  logic [AW-1:0] addr_a;
  logic [AW-1:0] addr_b;
  logic [AW-1:0] waddr;
  logic [AW-1:0] raddr;
  logic [7:0]  wdata;
  logic [7:0]  rdata;
  logic [8:0]  diff;

  // operand registers and loop state
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt   <= '0;
      ended <= 1'b0;
    end else begin
      if (cmd.load || cmd.clr_cnt) begin
        cnt <= '0;
      end else if (cmd.inc_cnt) begin
        cnt <= cnt + 1'b1;
      end
      if (cmd.load) begin
        ended <= 1'b0;
      end else if (cmd.set_ended) begin
        ended <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      act      <= act_t'(action);
      op0      <= first_operand;
      op1      <= second_operand;
      op2      <= third_operand;
      backward <= first_operand > second_operand;
    end
    if (cmd.lim_load) begin
      lim <= lim_next;
    end
    if (cmd.latch_a) begin
      byte_a <= rdata;
    end
    if (cmd.res_load) begin
      res <= res_next;
    end
  end

  // bytes left from each start address (valid once the start is in range)
  assign avail0    = CW'(MEM_W - op0);
  assign avail1    = CW'(MEM_W - op1);
  assign min_avail = (avail0 < avail1) ? avail0 : avail1;

  // loop bound
  always_comb begin
    unique case (cmd.lim_sel)
      LIM_OP2:    lim_next = op2[CW-1:0];
      LIM_STRN:   lim_next = (op1 < 64'(avail0)) ? op1[CW-1:0] : avail0;
      LIM_AVAIL0: lim_next = avail0;
      LIM_AVAIL1: lim_next = avail1;
      LIM_CMP:    lim_next = (act == ACT_STRNCMP && op2 < 64'(min_avail)) ?
                             op2[CW-1:0] : min_avail;
      LIM_CPY:    lim_next = cnt + 1'b1;
      default:    lim_next = '0;
    endcase
  end

  // byte addresses; copies toward higher addresses run backward
  assign j      = (cmd.copy_rev && backward) ? (lim - cnt - 1'b1) : cnt;
  assign addr_a = op0[AW-1:0] + j[AW-1:0];
  assign addr_b = op1[AW-1:0] + j[AW-1:0];
  assign raddr  = cmd.raddr_b ? addr_b : addr_a;
  assign waddr  = (cmd.wd_sel == WD_CLEAR) ? cnt[AW-1:0] : addr_a;

  always_comb begin
    unique case (cmd.wd_sel)
      WD_OP1:   wdata = op1[7:0] & BYTE_MASK;
      WD_RDATA: wdata = rdata;
      WD_ZERO:  wdata = 8'h00;
      WD_CLEAR: wdata = 8'h00;
      default:  wdata = 8'h00;
    endcase
  end

  gmse_ram #(
    .WIDTH(8),
    .DEPTH(MEM_BYTES)
  ) u_ram (
    .clk  (clk),
    .we   (cmd.we),
    .waddr(waddr),
    .wdata(wdata),
    .raddr(raddr),
    .rdata(rdata)
  );

  // result selection
  assign diff = {1'b0, byte_a} - {1'b0, rdata};

  always_comb begin
    unique case (cmd.res_sel)
      RES_ZERO: res_next = '0;
      RES_OP0:  res_next = op0;
      RES_CNT:  res_next = 64'(cnt);
      RES_BYTE: res_next = {56'd0, rdata};
      RES_DIFF: res_next = {{55{diff[8]}}, diff};
      RES_ADDR: res_next = op0 + 64'(cnt);
      default:  res_next = '0;
    endcase
  end

  assign result_value = res;

  // status toward the controller
  always_comb begin
    status.act        = act;
    status.in0        = op0 < MEM_W;
    status.in1        = op1 < MEM_W;
    status.z2         = op2 == 64'd0;
    status.fit0       = (op0 <= MEM_W) && (op2 <= MEM_W) && (op0 <= MEM_W - op2);
    status.fit1       = (op1 <= MEM_W) && (op2 <= MEM_W) && (op1 <= MEM_W - op2);
    status.fit_cpy    = op0 <= (MEM_W - 64'(cnt) - 64'd1);
    status.done_idx   = cnt == lim;
    status.src_end    = 64'(cnt) == (MEM_W - op1);
    status.clr_last   = cnt == CNT_LAST;
    status.byte_zero  = rdata == 8'h00;
    status.byte_ne    = byte_a != rdata;
    status.needle_hit = rdata == (op1[7:0] & BYTE_MASK);
    status.ended      = ended;
  end

endmodule

### hdl/gmse_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gmse_ctrl
// Controller: clears memory after reset, checks each request, then sequences
// the byte loop of the chosen service and issues the result strobe.
// ----------------------------------------------------------------------------
module gmse_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  output logic                 busy,
  output logic                 done,
  output gmse_pkg::dp_cmd_t    cmd,
  input  gmse_pkg::dp_status_t status
);
  import gmse_pkg::*;

  state_t state;
  state_t state_next;
  logic   phase;
  logic   phase_next;

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
      phase <= 1'b0;
    end else begin
      state <= state_next;
      phase <= phase_next;
    end
  end

  assign busy = state != ST_IDLE;
  assign done = state == ST_DONE;

  // next state and datapath commands
  always_comb begin
    state_next = state;
    phase_next = phase;
    cmd        = '0;
    cmd.lim_sel = LIM_OP2;
    cmd.wd_sel  = WD_ZERO;
    cmd.res_sel = RES_ZERO;
    // block moves may run from the top; the strcpy scan always runs forward
    cmd.copy_rev = (status.act == ACT_COPY) || (status.act == ACT_STRCPY && phase);

    unique case (state)
      ST_CLEAR: begin
        cmd.we      = 1'b1;
        cmd.wd_sel  = WD_CLEAR;
        cmd.inc_cnt = 1'b1;
        if (status.clr_last) begin
          state_next = ST_IDLE;
        end
      end

      ST_IDLE: begin
        if (start) begin
          cmd.load   = 1'b1;
          phase_next = 1'b0;
          state_next = ST_CHECK;
        end
      end

      // range checks and loop bound
      ST_CHECK: begin
        cmd.res_load = 1'b1;
        cmd.res_sel  = RES_ZERO;
        cmd.lim_load = 1'b1;
        state_next   = ST_DONE;
        case (status.act)
          ACT_WRITE: begin
            cmd.we     = status.in0;
            cmd.wd_sel = WD_OP1;
          end
          ACT_READ: begin
            if (status.in0) state_next = ST_RD_A;
          end
          ACT_COPY, ACT_SET: begin
            if (status.z2) begin
              cmd.res_sel = RES_OP0;
            end else if (status.fit0 && (status.fit1 || status.act == ACT_SET)) begin
              state_next = ST_TEST;
            end
          end
          ACT_MEMCMP: begin
            if (!status.z2 && status.fit0 && status.fit1) state_next = ST_TEST;
          end
          ACT_STRNLEN: begin
            cmd.lim_sel = LIM_STRN;
            if (status.in0) state_next = ST_TEST;
          end
          ACT_STRLEN, ACT_STRCHR: begin
            cmd.lim_sel = LIM_AVAIL0;
            if (status.in0) state_next = ST_TEST;
          end
          ACT_STRCMP, ACT_STRNCMP: begin
            cmd.lim_sel = LIM_CMP;
            if (status.in0 && status.in1) state_next = ST_TEST;
          end
          ACT_STRCPY: begin
            cmd.lim_sel = LIM_AVAIL1;
            if (status.in0 && status.in1) state_next = ST_TEST;
          end
          ACT_STRNCPY: begin
            if (status.in0 && status.in1) begin
              if (status.z2) begin
                cmd.res_sel = RES_OP0;
              end else if (status.fit0) begin
                state_next = ST_TEST;
              end
            end
          end
          default: begin
            state_next = ST_DONE;
          end
        endcase
      end

      // end of loop test, or a write step that needs no read
      ST_TEST: begin
        if (status.done_idx) begin
          cmd.res_load = 1'b1;
          state_next   = ST_DONE;
          case (status.act)
            ACT_COPY, ACT_SET, ACT_STRNCPY: cmd.res_sel = RES_OP0;
            ACT_STRNLEN, ACT_STRLEN:         cmd.res_sel = RES_CNT;
            ACT_STRCPY: cmd.res_sel = phase ? RES_OP0 : RES_ZERO;
            default:    cmd.res_sel = RES_ZERO;
          endcase
        end else if (status.act == ACT_SET) begin
          cmd.we      = 1'b1;
          cmd.wd_sel  = WD_OP1;
          cmd.inc_cnt = 1'b1;
        end else if (status.act == ACT_STRNCPY && status.ended) begin
          cmd.we      = 1'b1;
          cmd.wd_sel  = WD_ZERO;
          cmd.inc_cnt = 1'b1;
        end else if (status.act == ACT_STRNCPY && status.src_end) begin
          cmd.res_load = 1'b1;
          cmd.res_sel  = RES_ZERO;
          state_next   = ST_DONE;
        end else begin
          cmd.raddr_b = (status.act == ACT_COPY || status.act == ACT_STRNCPY ||
                         status.act == ACT_STRCPY);
          state_next  = ST_RD_A;
        end
      end

      // first read is in flight; compares then read the second string
      ST_RD_A: begin
        cmd.raddr_b = (status.act == ACT_COPY || status.act == ACT_STRNCPY ||
                       status.act == ACT_STRCPY);
        if (status.act == ACT_MEMCMP || status.act == ACT_STRCMP ||
            status.act == ACT_STRNCMP) begin
          state_next = ST_RD_B;
        end else begin
          state_next = ST_EVAL;
        end
      end

      ST_RD_B: begin
        cmd.latch_a = 1'b1;
        cmd.raddr_b = 1'b1;
        state_next  = ST_EVAL;
      end

      // byte is on the read port
      ST_EVAL: begin
        cmd.raddr_b = (status.act == ACT_COPY || status.act == ACT_STRNCPY ||
                       status.act == ACT_STRCPY);
        state_next  = ST_TEST;
        case (status.act)
          ACT_READ: begin
            cmd.res_load = 1'b1;
            cmd.res_sel  = RES_BYTE;
            state_next   = ST_DONE;
          end
          ACT_COPY: begin
            cmd.we      = 1'b1;
            cmd.wd_sel  = WD_RDATA;
            cmd.inc_cnt = 1'b1;
          end
          ACT_MEMCMP: begin
            if (status.byte_ne) begin
              cmd.res_load = 1'b1;
              cmd.res_sel  = RES_DIFF;
              state_next   = ST_DONE;
            end else begin
              cmd.inc_cnt = 1'b1;
            end
          end
          ACT_STRNLEN, ACT_STRLEN: begin
            if (status.byte_zero) begin
              cmd.res_load = 1'b1;
              cmd.res_sel  = RES_CNT;
              state_next   = ST_DONE;
            end else begin
              cmd.inc_cnt = 1'b1;
            end
          end
          ACT_STRCMP, ACT_STRNCMP: begin
            if (status.byte_ne) begin
              cmd.res_load = 1'b1;
              cmd.res_sel  = RES_DIFF;
              state_next   = ST_DONE;
            end else if (status.byte_zero) begin
              cmd.res_load = 1'b1;
              cmd.res_sel  = RES_ZERO;
              state_next   = ST_DONE;
            end else begin
              cmd.inc_cnt = 1'b1;
            end
          end
          ACT_STRCPY: begin
            if (phase) begin
              cmd.we      = 1'b1;
              cmd.wd_sel  = WD_RDATA;
              cmd.inc_cnt = 1'b1;
            end else if (status.byte_zero) begin
              // terminator found: copy length plus terminator if it fits
              if (status.fit_cpy) begin
                cmd.lim_load = 1'b1;
                cmd.lim_sel  = LIM_CPY;
                cmd.clr_cnt  = 1'b1;
                phase_next   = 1'b1;
              end else begin
                cmd.res_load = 1'b1;
                cmd.res_sel  = RES_ZERO;
                state_next   = ST_DONE;
              end
            end else begin
              cmd.inc_cnt = 1'b1;
            end
          end
          ACT_STRNCPY: begin
            cmd.we        = 1'b1;
            cmd.wd_sel    = WD_RDATA;
            cmd.inc_cnt   = 1'b1;
            cmd.set_ended = status.byte_zero;
          end
          ACT_STRCHR: begin
            if (status.needle_hit) begin
              cmd.res_load = 1'b1;
              cmd.res_sel  = RES_ADDR;
              state_next   = ST_DONE;
            end else if (status.byte_zero) begin
              cmd.res_load = 1'b1;
              cmd.res_sel  = RES_ZERO;
              state_next   = ST_DONE;
            end else begin
              cmd.inc_cnt = 1'b1;
            end
          end
          default: begin
            cmd.res_load = 1'b1;
            cmd.res_sel  = RES_ZERO;
            state_next   = ST_DONE;
          end
        endcase
      end

      ST_DONE: begin
        state_next = ST_IDLE;
      end

      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

### hdl/guest_memory_string_engine.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// guest_memory_string_engine
// Byte memory with bounds-checked string and memory services.
// ----------------------------------------------------------------------------
// Usage:
//   A transaction is taken when start is high and busy is low; action and the
//   three operands are sampled at that edge. busy stays high until the result
//   has been shown. done is high for exactly one cycle, with the result on
//   result_value; the receiver cannot stall and must take it then.
//   After reset the block sweeps the memory to zero, one byte per cycle, and
//   busy stays high until the sweep is done, before the first transaction.
//   Transactions run one at a time; the memory has one read port. Steps:
//     write byte, range errors: check, then done
//     read byte: check, read, evaluate, then done
//     set and strncpy zero fill: one write per loop test, no read
//     copy, strcpy copy phase, strncpy, length scans, strchr: test, read, evaluate
//     memcmp, strcmp, strncmp: test, two reads per position, evaluate
//     strcpy: scan of the source then the copy
//   plus the check and the result state, and a return to idle before the next
//   transaction. The registered read of the byte memory gives each read its
//   own state ahead of the evaluation.
// ----------------------------------------------------------------------------
module guest_memory_string_engine #(
  parameter int MEM_BYTES = gmse_pkg::MEM_BYTES_DEFAULT
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [3:0]  action,
  input  logic [63:0] first_operand,
  input  logic [63:0] second_operand,
  input  logic [63:0] third_operand,
  output logic        done,
  output logic [63:0] result_value
);
  import gmse_pkg::*;

  dp_cmd_t    cmd;
  dp_status_t status;

  gmse_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .busy  (busy),
    .done  (done),
    .cmd   (cmd),
    .status(status)
  );

  gmse_dp #(
    .MEM_BYTES(MEM_BYTES)
  ) u_dp (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .status        (status),
    .action        (action),
    .first_operand (first_operand),
    .second_operand(second_operand),
    .third_operand (third_operand),
    .result_value  (result_value)
  );

  // accepted transaction keeps the block busy in the next cycle
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> busy)
    else $error("busy not raised after accepted transaction");

  // result strobe only while a transaction is in flight
  a_done_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> busy)
    else $error("done without busy");

  // result strobe lasts a single cycle and frees the block
  a_done_single: assert property (@(posedge clk) disable iff (rst)
    done |=> !done && !busy)
    else $error("done longer than one cycle");

endmodule
